### rtl/core/lztd_pkg.sv
// ----------------------------------------------------------------------------
// lztd_pkg
// Shared constants for the LZSS token decoder: token field widths, the code
// split of the second byte and the window fill value.
// ----------------------------------------------------------------------------
package lztd_pkg;

   // token fields
   localparam int BYTE_W     = 8;
   localparam int POS_W      = 12;  // absolute window position in a code
   localparam int LEN_CODE_W = 4;   // length code in the low nibble

   // window contents before anything is written
   localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h20;

   // request payload as it sits in req_tdata
   typedef struct packed {
      logic [BYTE_W-1:0] second_byte;
      logic [BYTE_W-1:0] first_byte;
   } req_data_type;

endpackage

### rtl/core/lztd_ram.sv
// ----------------------------------------------------------------------------
// lztd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is enabled.
// ----------------------------------------------------------------------------
module lztd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/lzss_token_decoder.sv
// ----------------------------------------------------------------------------
// lzss_token_decoder
// Decodes LZSS tokens (literal or position/length code) into a byte stream
// using a circular history window held in a synchronous RAM.
// ----------------------------------------------------------------------------
// A literal token gives one byte. A match token of
// length L = code + SHORTEST_CODED + 1 gives L bytes: once it is accepted
// (and WINDOW_DEPTH has been subtracted, as often as needed, when the coded
// position lies beyond a window smaller than 4096), the window RAM is read
// one byte per cycle, while the output is not stalled, into the output
// register and a copy buffer RAM, then the copy buffer is written back
// through the window's single write port one byte per cycle.
// No token is taken while a match is in progress. The window needs no
// clearing pass after reset: bytes are always written in order from
// position zero, so a fill flag and the write pointer tell which entries
// still read as spaces.
// ----------------------------------------------------------------------------
module lzss_token_decoder #(
   parameter int WINDOW_DEPTH   = 4096,
   parameter int SHORTEST_CODED = 2
) (
   input  logic        clock,
   input  logic        reset,
   // token in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] first_byte, [15:8] second_byte
   input  logic        req_tuser,   // [0] is_literal
   input  logic        req_tlast,   // final_token
   // decoded bytes out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] data_byte
   output logic        rsp_tuser,   // [0] last_of_token
   output logic        rsp_tlast    // stream_end
);

   localparam int AW      = $clog2(WINDOW_DEPTH);
   localparam int LONGEST = (1 << lztd_pkg::LEN_CODE_W) + SHORTEST_CODED;
   localparam int CW      = $clog2(LONGEST + 1);
   localparam int CBW     = $clog2(LONGEST);
   localparam int PW      = lztd_pkg::POS_W;
   localparam logic [PW:0]   DEPTH_WIDE = (PW+1)'(WINDOW_DEPTH);
   localparam logic [PW-1:0] POS_TOP    = PW'(WINDOW_DEPTH - 1);
   localparam logic [AW-1:0] PTR_TOP    = AW'(WINDOW_DEPTH - 1);
   localparam logic [CW-1:0] LEN_BIAS   = CW'(SHORTEST_CODED + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_WRITE} state_type;

   state_type                   state_ff, state_in;
   logic [AW-1:0]               wptr_ff, wptr_in;
   logic                        full_ff, full_in;
   logic [PW-1:0]               pos_ff, pos_in;
   logic [CW-1:0]               len_ff, len_in;
   logic [CW-1:0]               rdcnt_ff, rdcnt_in;
   logic [CW-1:0]               mvcnt_ff, mvcnt_in;
   logic [CW-1:0]               wcnt_ff, wcnt_in;
   logic                        fin_ff, fin_in;
   logic                        dv_ff, dv_in;
   logic                        dfresh_ff, dfresh_in;
   logic                        dlast_ff, dlast_in;
   logic                        wv_ff, wv_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [lztd_pkg::BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_end_ff, rsp_end_in;

   lztd_pkg::req_data_type      req_data;
   logic                        rsp_free;
   logic                        reducing;
   logic                        issue;
   logic                        move;
   logic [lztd_pkg::BYTE_W-1:0] read_byte;
   logic [PW-1:0]               pos_next;
   logic [AW-1:0]               wptr_next;

   logic                        win_we, win_re;
   logic [AW-1:0]               win_waddr;
   logic [lztd_pkg::BYTE_W-1:0] win_wdata, win_rdata;
   logic                        cb_we, cb_re;
   logic [lztd_pkg::BYTE_W-1:0] cb_rdata;

   assign req_data = lztd_pkg::req_data_type'(req_tdata);

   // history window
   lztd_ram #(
      .WIDTH(lztd_pkg::BYTE_W),
      .DEPTH(WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (win_waddr),
      .wr_data (win_wdata),
      .rd_en   (win_re),
      .rd_addr (pos_ff[AW-1:0]),
      .rd_data (win_rdata)
   );

   // staging for one match until its bytes go back into the window
   lztd_ram #(
      .WIDTH(lztd_pkg::BYTE_W),
      .DEPTH(LONGEST)
   ) u_copy_buf (
      .clock   (clock),
      .wr_en   (cb_we),
      .wr_addr (mvcnt_ff[CBW-1:0]),
      .wr_data (read_byte),
      .rd_en   (cb_re),
      .rd_addr (wcnt_ff[CBW-1:0]),
      .rd_data (cb_rdata)
   );

   // common terms
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign reducing  = ({1'b0, pos_ff} >= DEPTH_WIDE);
   assign move      = (state_ff == ST_READ) && dv_ff && rsp_free;
   assign issue     = (state_ff == ST_READ) && !reducing && (rdcnt_ff != len_ff)
                      && (!dv_ff || move);
   assign read_byte = dfresh_ff ? win_rdata : lztd_pkg::FILL_BYTE;
   assign pos_next  = (pos_ff == POS_TOP) ? '0 : pos_ff + PW'(1);
   assign wptr_next = (wptr_ff == PTR_TOP) ? '0 : wptr_ff + AW'(1);

   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign win_re     = issue;
   assign cb_we      = move;
   assign cb_re      = (state_ff == ST_WRITE) && (wcnt_ff != len_ff);

   // window write: a literal on accept, or a staged byte during write-back
   always_comb begin
      win_we    = 1'b0;
      win_waddr = wptr_ff;
      win_wdata = req_data.first_byte;
      if (state_ff == ST_IDLE) begin
         win_we = req_tvalid && req_tready && req_tuser;
      end else if (state_ff == ST_WRITE) begin
         win_we    = wv_ff;
         win_wdata = cb_rdata;
      end
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      wptr_in      = wptr_ff;
      full_in      = full_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      rdcnt_in     = rdcnt_ff;
      mvcnt_in     = mvcnt_ff;
      wcnt_in      = wcnt_ff;
      fin_in       = fin_ff;
      dv_in        = dv_ff;
      dfresh_in    = dfresh_ff;
      dlast_in     = dlast_ff;
      wv_in        = 1'b0;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;

      // pointer advances on every window write
      if (win_we) begin
         wptr_in = wptr_next;
         if (wptr_ff == PTR_TOP) begin
            full_in = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               fin_in = req_tlast;
               if (req_tuser) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = req_data.first_byte;
                  rsp_last_in  = 1'b1;
                  rsp_end_in   = req_tlast;
               end else begin
                  pos_in   = {req_data.first_byte,
                              req_data.second_byte[7:lztd_pkg::LEN_CODE_W]};
                  len_in   = CW'(req_data.second_byte[lztd_pkg::LEN_CODE_W-1:0])
                             + LEN_BIAS;
                  rdcnt_in = '0;
                  mvcnt_in = '0;
                  dv_in    = 1'b0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // fold a position beyond a small window back into range
            if (reducing) begin
               pos_in = PW'({1'b0, pos_ff} - DEPTH_WIDE);
            end
            // read data register to output register and copy buffer
            if (move) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = read_byte;
               rsp_last_in  = dlast_ff;
               rsp_end_in   = dlast_ff && fin_ff;
               mvcnt_in     = mvcnt_ff + CW'(1);
               dv_in        = 1'b0;
               if (dlast_ff) begin
                  wcnt_in  = '0;
                  state_in = ST_WRITE;
               end
            end
            // next window read; unwritten entries still read as spaces
            if (issue) begin
               dv_in     = 1'b1;
               dfresh_in = full_ff || (pos_ff[AW-1:0] < wptr_ff);
               dlast_in  = (rdcnt_ff + CW'(1)) == len_ff;
               rdcnt_in  = rdcnt_ff + CW'(1);
               pos_in    = pos_next;
            end
         end
         ST_WRITE: begin
            if (cb_re) begin
               wcnt_in = wcnt_ff + CW'(1);
               wv_in   = 1'b1;
            end
            if (wv_ff && (wcnt_ff == len_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wptr_ff      <= '0;
         full_ff      <= 1'b0;
         dv_ff        <= 1'b0;
         wv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wptr_ff      <= wptr_in;
         full_ff      <= full_in;
         dv_ff        <= dv_in;
         wv_ff        <= wv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      len_ff      <= len_in;
      rdcnt_ff    <= rdcnt_in;
      mvcnt_ff    <= mvcnt_in;
      wcnt_ff     <= wcnt_in;
      fin_ff      <= fin_in;
      dfresh_ff   <= dfresh_in;
      dlast_ff    <= dlast_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_last_ff;
   assign rsp_tlast  = rsp_end_ff;

   // window is never read and written in the same cycle
   a_win_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(win_we && win_re))
      else $error("window read and write in the same cycle");

   // a new token is taken only between matches
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == ST_IDLE))
      else $error("token accepted during a match");

   // once the window has wrapped it stays fully written
   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      full_ff |=> full_ff)
      else $error("window fill flag dropped");

   // read data is pending only while reading a match
   a_dv_in_read: assert property (@(posedge clock) disable iff (reset)
      dv_ff |-> (state_ff == ST_READ))
      else $error("window read data pending outside read phase");

endmodule
